FILE: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions of the text console writer
// Widths, codes and the cursor status record used by the console modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Default screen geometry.
	localparam int TCW_COLUMNS = 80;
	localparam int TCW_ROWS    = 25;

	// Field widths. LIN_W covers the largest linear index of any legal geometry.
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int LIN_W  = 12;
	localparam int CELL_W = 16;
	localparam int POS_W  = 11;

	// Operation codes carried in the input tuser bit.
	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// A space on attribute 0.
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;

	// Cursor status handed from the cursor unit to the controller.
	typedef struct packed {
		logic [LIN_W-1:0] lin;       // linear cursor index row*COLUMNS+column
		logic [LIN_W-1:0] base;      // physical start of the top logical row
		logic             wrap_last; // the next put scrolls the screen
	} cur_stat_t;

endpackage

FILE: hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic single-port synchronous RAM
// One access per cycle, write or read, with the read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: hdl/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor: cursor and scroll base of the text console
// Keeps column, row and linear cursor index, and the rotating row base that
// turns a scroll into a base step plus one cleared row.
// ----------------------------------------------------------------------------
module tcw_cursor
	import tcw_pkg::*;
#(
	parameter int COLUMNS = TCW_COLUMNS,
	parameter int ROWS    = TCW_ROWS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	output cur_stat_t stat
);

	localparam int CELLS = COLUMNS * ROWS;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [LIN_W-1:0] lin_q;
	logic [LIN_W-1:0] base_q;
	logic             end_col;
	logic             end_row;
	logic [LIN_W-1:0] base_step;

	assign end_col   = (col_q == COL_W'(COLUMNS - 1));
	assign end_row   = (row_q == ROW_W'(ROWS - 1));
	assign base_step = base_q + LIN_W'(COLUMNS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			lin_q  <= '0;
			base_q <= '0;
		end else if (adv) begin
			if (end_col) begin
				col_q <= '0;
				if (end_row) begin
					// The cursor stays on the last row and the screen moves up.
					lin_q  <= LIN_W'((ROWS - 1) * COLUMNS);
					base_q <= (base_step == LIN_W'(CELLS)) ? '0 : base_step;
				end else begin
					row_q <= row_q + 1'b1;
					lin_q <= lin_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
				lin_q <= lin_q + 1'b1;
			end
		end
	end

	assign stat.lin       = lin_q;
	assign stat.base      = base_q;
	assign stat.wrap_last = end_col && end_row;

endmodule

FILE: hdl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit: text-mode console engine
// Character store with cursor, line wrap and scroll through a row base.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready. s_tuser selects the operation:
//   a put writes char_code with its colors at the cursor and advances it, a
//   read fetches the cell at read_position. Every word yields one result word
//   on m_tvalid/m_tready with the cursor position after the item.
//   A put goes from the accepting edge through the emit state into the
//   output register; a read first passes the read state, which takes the
//   registered RAM read data. A put that scrolls first passes the scroll
//   state, which blanks, cell by cell, the row that becomes the bottom line;
//   the rows themselves never move, only the row base held by the cursor
//   unit. With the single RAM port and the one-item-at-a-time controller,
//   the next word is taken only once the emit state has returned to idle.
//   After reset the store is cleared to zero, one cell a cycle; s_tready
//   stays low meanwhile. If the receiver stalls, the result waits in the
//   output register, the result of the following word waits in the emit
//   state until that register frees, and s_tready stays low.
// ----------------------------------------------------------------------------
module text_console_writer_unit
	import tcw_pkg::*;
#(
	parameter int COLUMNS = TCW_COLUMNS,
	parameter int ROWS    = TCW_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // char_code[7:0], fg_color[11:8], bg_color[15:12],
	                              // read_position[26:16], zero fill
	input  logic        s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // cursor_position[10:0], scrolled[11], read_word[27:12],
	                              // zero fill
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam logic [LIN_W:0] CELLS_X = (LIN_W + 1)'(CELLS);

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_READ   = 5'b00100,
		ST_SCROLL = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t            state_q;
	cur_stat_t         stat;
	logic              in_acc;
	logic              emit_go;
	logic              is_put;
	logic [7:0]        char_code;
	logic [3:0]        fg_color;
	logic [3:0]        bg_color;
	logic [POS_W-1:0]  read_position;
	logic [LIN_W:0]    cur_sum;
	logic [LIN_W:0]    cur_wrap;
	logic [LIN_W:0]    rd_sum;
	logic [LIN_W:0]    rd_wrap;
	logic              rd_oob;
	logic              ram_en;
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [CELL_W-1:0] ram_wdata;
	logic [CELL_W-1:0] ram_rdata;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     sweep_q;
	logic [COL_W-1:0]  sweep_cnt_q;
	logic              oob_q;
	logic              res_scr_q;
	logic [CELL_W-1:0] res_word_q;
	logic              m_tvalid_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              out_scr_q;
	logic [CELL_W-1:0] out_word_q;

	assign char_code     = s_tdata[7:0];
	assign fg_color      = s_tdata[11:8];
	assign bg_color      = s_tdata[15:12];
	assign read_position = s_tdata[26:16];
	assign is_put        = (s_tuser == OP_PUT);

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign emit_go  = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	// Logical index plus row base, folded back into the store once.
	assign cur_sum  = {1'b0, stat.lin} + {1'b0, stat.base};
	assign cur_wrap = (cur_sum >= CELLS_X) ? cur_sum - CELLS_X : cur_sum;
	assign rd_sum   = (LIN_W + 1)'(read_position) + {1'b0, stat.base};
	assign rd_wrap  = (rd_sum >= CELLS_X) ? rd_sum - CELLS_X : rd_sum;
	assign rd_oob   = ((LIN_W + 1)'(read_position) >= CELLS_X);

	tcw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_cursor (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (in_acc && is_put),
		.stat  (stat)
	);

	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			ST_IDLE: begin
				if (in_acc) begin
					if (is_put) begin
						ram_en    = 1'b1;
						ram_we    = 1'b1;
						ram_addr  = cur_wrap[AW-1:0];
						ram_wdata = {bg_color, fg_color, char_code};
					end else begin
						ram_en   = !rd_oob;
						ram_addr = rd_wrap[AW-1:0];
					end
				end
			end
			ST_SCROLL: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = sweep_q;
				ram_wdata = BLANK_CELL;
			end
			ST_READ, ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			sweep_q     <= '0;
			sweep_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						if (!is_put) begin
							state_q <= ST_READ;
						end else if (stat.wrap_last) begin
							// The old top row becomes the new bottom row.
							sweep_q     <= stat.base[AW-1:0];
							sweep_cnt_q <= '0;
							state_q     <= ST_SCROLL;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_SCROLL: begin
					sweep_q     <= sweep_q + 1'b1;
					sweep_cnt_q <= sweep_cnt_q + 1'b1;
					if (sweep_cnt_q == COL_W'(COLUMNS - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload held until the output register takes it.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			oob_q      <= rd_oob;
			res_scr_q  <= is_put && stat.wrap_last;
			res_word_q <= '0;
		end
		if (state_q == ST_READ) begin
			res_word_q <= oob_q ? '0 : ram_rdata;
		end
		if (emit_go) begin
			out_pos_q  <= stat.lin[POS_W-1:0];
			out_scr_q  <= res_scr_q;
			out_word_q <= res_word_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, out_word_q, out_scr_q, out_pos_q};

endmodule
